// ----- hw/rtl/bba_pkg.sv -----
// package: constants, types and helper functions of the buddy bitmap allocator
package bba_pkg;

  localparam int unsigned POOL_BYTES      = 16384;
  localparam int unsigned MIN_BLOCK_BYTES = 64;
  localparam int unsigned MIN_SHIFT       = $clog2(MIN_BLOCK_BYTES);
  localparam int unsigned NUM_BLK         = POOL_BYTES / MIN_BLOCK_BYTES;
  localparam int unsigned TOP_LVL         = $clog2(NUM_BLK);
  localparam int unsigned LVL_W           = $clog2(TOP_LVL + 1);
  localparam int unsigned IDX_W           = (TOP_LVL > 0) ? TOP_LVL : 1;
  localparam int unsigned BIT_W           = $clog2(2 * NUM_BLK);
  localparam int unsigned WORD_BITS       = 16;
  localparam int unsigned WPOS_W          = $clog2(WORD_BITS);
  localparam int unsigned NUM_WORDS       = (2 * NUM_BLK) / WORD_BITS;
  localparam int unsigned WADDR_W         = $clog2(NUM_WORDS);
  localparam int unsigned PAIRS           = WORD_BITS / 2;
  localparam int unsigned BYTES_W         = 15;
  localparam int unsigned OFFS_W          = 14;
  localparam int unsigned SHIFT_W         = $clog2(TOP_LVL + MIN_SHIFT + 1);

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_TOO_BIG  = 2'd1,
    ST_NO_SPACE = 2'd2
  } status_e;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [0:0]         kind;
    logic [BYTES_W-1:0] request_bytes;
    logic [OFFS_W-1:0]  block_offset;
  } req_t;

  typedef struct packed {
    logic [OFFS_W-1:0] block_address;
    status_e           status;
  } res_t;

  // first bit of a level in the flat bitmap
  function automatic logic [BIT_W-1:0] level_base(input logic [LVL_W-1:0] lvl);
    logic [BIT_W-1:0] b;
    b = '0;
    for (int k = 0; k <= TOP_LVL; k++) begin
      if (k < int'(lvl)) begin
        b = b + BIT_W'(NUM_BLK >> k);
      end
    end
    return b;
  endfunction

  // number of blocks in a level
  function automatic logic [BIT_W-1:0] level_cnt(input logic [LVL_W-1:0] lvl);
    return BIT_W'(NUM_BLK) >> lvl;
  endfunction

  // smallest level whose block holds the given size
  function automatic logic [LVL_W-1:0] size_level(input logic [BYTES_W-1:0] bytes);
    logic [LVL_W-1:0] l;
    logic             fnd;
    l   = LVL_W'(TOP_LVL);
    fnd = 1'b0;
    for (int k = 0; k <= TOP_LVL; k++) begin
      if (!fnd && (32'(bytes) <= (MIN_BLOCK_BYTES << k))) begin
        l   = LVL_W'(k);
        fnd = 1'b1;
      end
    end
    return l;
  endfunction

endpackage

// ----- hw/rtl/buddy_bitmap_allocator_top.sv -----
// top level: buddy bitmap allocator with registered result stage
// steps: allocate scans the 16-bit bitmap words level by level, then marks each level
//   from the hit down to the request level; free clears and merges level by level
// throughput: one request at a time, set by the single bitmap ram port pair
// reset: a clearing pass zeroes all 32 bitmap words before the first request
module buddy_bitmap_allocator_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [0:0]                  kind_i,
  input  logic [bba_pkg::BYTES_W-1:0] request_bytes_i,
  input  logic [bba_pkg::OFFS_W-1:0]  block_offset_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bba_pkg::OFFS_W-1:0]  block_address_o,
  output logic [1:0]                  status_o
);
  import bba_pkg::*;

  req_t              req;
  res_t              res;
  logic              res_valid, res_ready;
  logic              out_valid_q;
  logic [OFFS_W-1:0] addr_q;
  logic [1:0]        status_q;

  assign req = '{kind: kind_i, request_bytes: request_bytes_i, block_offset: block_offset_i};
  assign res_ready = !out_valid_q || !out_stall_i;

  bba_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_i       (req),
    .req_stall_o (in_stall_o),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      addr_q   <= res.block_address;
      status_q <= res.status;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign block_address_o = addr_q;
  assign status_o        = status_q;

endmodule

// ----- hw/rtl/bba_ram.sv -----
// generic single-port-write, registered-read ram
module bba_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/bba_seq.sv -----
// sequencer: clearing pass, level scan, split marking and merge walk over the bitmap ram
module bba_seq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  bba_pkg::req_t req_i,
  output logic          req_stall_o,
  output logic          res_valid_o,
  output bba_pkg::res_t res_o,
  input  logic          res_ready_i
);
  import bba_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_MARK_RD, S_MARK_WR,
    S_FREE_RD, S_FREE_WR, S_OUT
  } state_e;

  state_e               state_q, state_d;
  logic [LVL_W-1:0]     lvl_q, lvl_d;
  logic [LVL_W-1:0]     j_q, j_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [WADDR_W-1:0]   word_q, word_d;
  res_t                 res_q, res_d;

  logic                 we, re;
  logic [WADDR_W-1:0]   waddr, raddr;
  logic [WORD_BITS-1:0] wdata, rdata;

  logic [BIT_W-1:0]     base_j, cnt_j, gbit, gpair, last_bit;
  logic [WPOS_W-1:0]    bpos, ppos;
  logic [WORD_BITS-1:0] bmask, set_word, clr_word;
  logic                 hit;
  logic [IDX_W-1:0]     hit_idx;
  logic [LVL_W-1:0]     rlvl;
  logic [SHIFT_W-1:0]   fshift;

  bba_ram #(.DEPTH(NUM_WORDS), .WIDTH(WORD_BITS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    base_j   = level_base(j_q);
    cnt_j    = level_cnt(j_q);
    last_bit = base_j + cnt_j - BIT_W'(1);
    gbit     = base_j + BIT_W'(idx_q);
    bpos     = gbit[WPOS_W-1:0];
    bmask    = WORD_BITS'(1) << bpos;
    set_word = rdata | bmask;
    clr_word = rdata & ~bmask;
    ppos     = {bpos[WPOS_W-1:1], 1'b0};
  end

  // first pair in the word with exactly one block in use; at the root level, a free root block
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    gpair   = '0;
    if (j_q == LVL_W'(TOP_LVL)) begin
      hit = !rdata[base_j[WPOS_W-1:0]];
    end else begin
      for (int k = 0; k < PAIRS; k++) begin
        gpair = {word_q, WPOS_W'(2 * k)};
        if (!hit && gpair >= base_j && gpair <= last_bit &&
            (rdata[2*k] ^ rdata[2*k+1])) begin
          hit     = 1'b1;
          hit_idx = IDX_W'(gpair - base_j) + IDX_W'(rdata[2*k]);
        end
      end
    end
  end

  always_comb begin
    rlvl   = size_level(req_i.request_bytes);
    fshift = SHIFT_W'(rlvl) + SHIFT_W'(MIN_SHIFT);
  end

  always_comb begin
    state_d = state_q;
    lvl_d   = lvl_q;
    j_d     = j_q;
    idx_d   = idx_q;
    word_d  = word_q;
    res_d   = res_q;
    we      = 1'b0;
    re      = 1'b0;
    waddr   = gbit[BIT_W-1:WPOS_W];
    raddr   = gbit[BIT_W-1:WPOS_W];
    wdata   = set_word;
    unique case (state_q)
      S_CLR: begin
        we    = 1'b1;
        waddr = word_q;
        wdata = '0;
        if (word_q == WADDR_W'(NUM_WORDS - 1)) begin
          state_d = S_IDLE;
        end else begin
          word_d = word_q + WADDR_W'(1);
        end
      end
      S_IDLE: begin
        if (req_valid_i) begin
          res_d = '{block_address: '0, status: ST_DONE};
          lvl_d = rlvl;
          j_d   = rlvl;
          if (32'(req_i.request_bytes) > POOL_BYTES) begin
            res_d.status = ST_TOO_BIG;
            state_d      = S_OUT;
          end else if (req_i.kind == KIND_FREE) begin
            idx_d   = IDX_W'(req_i.block_offset >> fshift);
            state_d = S_FREE_RD;
          end else begin
            word_d  = WADDR_W'(level_base(rlvl) >> WPOS_W);
            state_d = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        re      = 1'b1;
        raddr   = word_q;
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (hit) begin
          idx_d   = hit_idx;
          state_d = S_MARK_RD;
        end else if (word_q == last_bit[BIT_W-1:WPOS_W]) begin
          if (j_q == LVL_W'(TOP_LVL)) begin
            res_d.status = ST_NO_SPACE;
            state_d      = S_OUT;
          end else begin
            j_d     = j_q + LVL_W'(1);
            word_d  = WADDR_W'(level_base(j_q + LVL_W'(1)) >> WPOS_W);
            state_d = S_SCAN_RD;
          end
        end else begin
          word_d  = word_q + WADDR_W'(1);
          state_d = S_SCAN_RD;
        end
      end
      S_MARK_RD: begin
        re      = 1'b1;
        state_d = S_MARK_WR;
      end
      S_MARK_WR: begin
        we    = 1'b1;
        wdata = set_word;
        if (j_q == lvl_q) begin
          res_d.block_address = OFFS_W'(OFFS_W'(idx_q) << (SHIFT_W'(lvl_q) +
                                                          SHIFT_W'(MIN_SHIFT)));
          state_d = S_OUT;
        end else begin
          j_d     = j_q - LVL_W'(1);
          idx_d   = idx_q << 1;
          state_d = S_MARK_RD;
        end
      end
      S_FREE_RD: begin
        re      = 1'b1;
        state_d = S_FREE_WR;
      end
      S_FREE_WR: begin
        we    = 1'b1;
        wdata = clr_word;
        if (j_q != LVL_W'(TOP_LVL) && !clr_word[ppos] && !clr_word[ppos + WPOS_W'(1)]) begin
          j_d     = j_q + LVL_W'(1);
          idx_d   = idx_q >> 1;
          state_d = S_FREE_RD;
        end else begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      word_q  <= '0;
      lvl_q   <= '0;
      j_q     <= '0;
      idx_q   <= '0;
      res_q   <= '{block_address: '0, status: ST_DONE};
    end else begin
      state_q <= state_d;
      word_q  <= word_d;
      lvl_q   <= lvl_d;
      j_q     <= j_d;
      idx_q   <= idx_d;
      res_q   <= res_d;
    end
  end

  assign req_stall_o = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_OUT) && res_ready_i;
  assign res_o       = res_q;

  a_rw_excl : assert property (@(posedge clk_i) disable iff (!rst_ni) !(we && re))
    else $error("ram read and write in one cycle");
  a_lvl_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    j_q <= LVL_W'(TOP_LVL))
    else $error("level beyond root");
  a_mark_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MARK_WR) |-> (j_q >= lvl_q))
    else $error("split marking below request level");
  a_err_addr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status != ST_DONE) |-> (res_o.block_address == '0))
    else $error("address on failed request");

endmodule

// ----- tb/buddy_bitmap_allocator_checker.sv -----
// checker: watches both channels, predicts allocator results and compares them
`timescale 1ns / 100ps
module buddy_bitmap_allocator_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [0:0]                  kind_i,
  input  logic [bba_pkg::BYTES_W-1:0] request_bytes_i,
  input  logic [bba_pkg::OFFS_W-1:0]  block_offset_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [bba_pkg::OFFS_W-1:0]  block_address_i,
  input  logic [1:0]                  status_i,
  output int                          fail_count_o,
  output int                          pending_o
);
  import bba_pkg::*;

  localparam int TOP = TOP_LVL;

  typedef struct packed {
    logic [OFFS_W-1:0] addr;
    status_e           st;
  } grant_t;

  logic   used_map [0:TOP][0:NUM_BLK-1];
  grant_t grants_q [$];
  int     fails;

  assign fail_count_o = fails;
  assign pending_o    = grants_q.size();

  function automatic int lvl_of(input int bytes);
    int l;
    int sz;
    l  = 0;
    sz = MIN_BLOCK_BYTES;
    while (sz < bytes && l < TOP) begin
      sz = sz << 1;
      l++;
    end
    return l;
  endfunction

  function automatic int pick_block(input int lvl);
    int n;
    n = NUM_BLK >> lvl;
    if (lvl == TOP) return used_map[TOP][0] ? -1 : 0;
    for (int i = 0; i + 1 < n; i += 2) begin
      if (!used_map[lvl][i] && used_map[lvl][i+1]) return i;
      if (used_map[lvl][i] && !used_map[lvl][i+1]) return i + 1;
    end
    return -1;
  endfunction

  function automatic grant_t serve(input logic k, input int bytes, input int offs);
    grant_t g;
    int lvl, idx, j, hit, u;
    g.addr = '0;
    g.st   = ST_DONE;
    if (bytes > POOL_BYTES) begin
      g.st = ST_TOO_BIG;
    end else if (k == KIND_ALLOC) begin
      lvl = lvl_of(bytes);
      idx = pick_block(lvl);
      if (idx < 0) begin
        hit = -1;
        for (j = lvl + 1; j <= TOP; j++) begin
          hit = pick_block(j);
          if (hit >= 0) break;
        end
        if (hit < 0) begin
          g.st = ST_NO_SPACE;
        end else begin
          u = hit;
          used_map[j][u] = 1'b1;
          for (int m = j - 1; m > lvl; m--) begin
            u = u << 1;
            used_map[m][u] = 1'b1;
          end
          idx = u << 1;
        end
      end
      if (g.st == ST_DONE) begin
        used_map[lvl][idx] = 1'b1;
        g.addr = OFFS_W'((MIN_BLOCK_BYTES << lvl) * idx);
      end
    end else begin
      lvl = lvl_of(bytes);
      idx = offs / (MIN_BLOCK_BYTES << lvl);
      if (idx >= (NUM_BLK >> lvl)) begin
        g.st = ST_TOO_BIG;
      end else begin
        used_map[lvl][idx] = 1'b0;
        while (lvl < TOP) begin
          if (used_map[lvl][idx] || used_map[lvl][idx ^ 1]) break;
          idx = idx >> 1;
          lvl++;
          used_map[lvl][idx] = 1'b0;
        end
      end
    end
    return g;
  endfunction

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t exp_g;
    if (!rst_ni) begin
      fails = 0;
      grants_q.delete();
      for (int l = 0; l <= TOP; l++)
        for (int i = 0; i < NUM_BLK; i++) used_map[l][i] = 1'b0;
    end else begin
      if (in_valid_i && !in_stall_i)
        grants_q.push_back(serve(kind_i, int'(request_bytes_i), int'(block_offset_i)));
      if (out_valid_i && !out_stall_i) begin
        if (grants_q.size() == 0) begin
          report("result with no request waiting");
        end else begin
          exp_g = grants_q.pop_front();
          if (block_address_i !== exp_g.addr)
            report($sformatf("block_address %0d, expected %0d", block_address_i, exp_g.addr));
          if (status_i !== exp_g.st)
            report($sformatf("status %0d, expected %0d", status_i, exp_g.st));
        end
      end
    end
  end
endmodule

// ----- tb/buddy_bitmap_allocator_top_tb.sv -----
// testbench top: drives allocate and free requests and gives the verdict
`timescale 1ns / 100ps
module buddy_bitmap_allocator_top_tb;
  import bba_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [0:0]         kind_i = '0;
  logic [BYTES_W-1:0] request_bytes_i = '0;
  logic [OFFS_W-1:0]  block_offset_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [OFFS_W-1:0]  block_address_o;
  logic [1:0]         status_o;
  int                 fail_count;
  int                 pending;
  int                 send_idle_pct = 0;
  int                 stall_pct = 0;
  int                 quiet_cycles = 0;
  logic [OFFS_W-1:0]  held_q [$];

  always #5 clk_i = ~clk_i;

  buddy_bitmap_allocator_top uut (.*);

  buddy_bitmap_allocator_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .kind_i, .request_bytes_i,
    .block_offset_i, .out_valid_i(out_valid_o), .out_stall_i, .block_address_i(block_address_o),
    .status_i(status_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("buddy_bitmap_allocator_top_tb: done, errors");
      $finish;
    end
  end

  // keep a record of granted blocks so frees mostly name real ones
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i && status_o == ST_DONE && block_address_o != 0
        && held_q.size() < 64)
      held_q.push_back(block_address_o);
  end

  task automatic send(input logic k, input int bytes, input int offs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    kind_i          <= k;
    request_bytes_i <= BYTES_W'(bytes);
    block_offset_i  <= OFFS_W'(offs);
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic int rand_size();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(512);
    if (r < 90) return $urandom_range(POOL_BYTES);
    if (r < 95) return $urandom_range(32767);
    return POOL_BYTES;
  endfunction

  task automatic random_phase(input int n, input int idle, input int stall);
    int offs;
    send_idle_pct = idle;
    stall_pct     = stall;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 55) begin
        send(KIND_ALLOC, rand_size(), $urandom_range(16383));
      end else if (held_q.size() > 0 && $urandom_range(99) < 80) begin
        offs = held_q.pop_front();
        send(KIND_FREE, $urandom_range(256), offs);
      end else begin
        send(KIND_FREE, rand_size(), $urandom_range(16383));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send(KIND_ALLOC, 0, 0);
    send(KIND_ALLOC, 1, 16383);
    send(KIND_ALLOC, 64, 0);
    send(KIND_ALLOC, 65, 0);
    send(KIND_ALLOC, POOL_BYTES, 0);
    send(KIND_ALLOC, POOL_BYTES + 1, 0);
    send(KIND_ALLOC, 32767, 0);
    send(KIND_FREE, 32767, 0);
    send(KIND_FREE, 64, 16383);
    send(KIND_FREE, 128, 100);
    send(KIND_FREE, 0, 0);
    send(KIND_FREE, 64, 64);
    send(KIND_ALLOC, 8192, 0);
    send(KIND_ALLOC, 8192, 0);
    send(KIND_ALLOC, 8192, 0);
    send(KIND_ALLOC, 64, 0);
    send(KIND_FREE, POOL_BYTES, 0);
    send(KIND_ALLOC, POOL_BYTES, 0);
    send(KIND_ALLOC, POOL_BYTES, 0);
    send(KIND_FREE, POOL_BYTES, 12345);
    send(KIND_FREE, 5000, 10922);
    random_phase(400, 0, 0);
    random_phase(400, 58, 0);
    random_phase(400, 0, 58);
    random_phase(400, 34, 34);
    in_valid_i <= 1'b0;
    send_idle_pct = 0;
    wait (pending == 0);
    stall_pct = 0;
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("buddy_bitmap_allocator_top_tb: done, clean");
    end else begin
      $display("buddy_bitmap_allocator_top_tb: done, errors");
    end
    $finish;
  end
endmodule

// ----- files.f -----
hw/rtl/bba_pkg.sv
hw/rtl/bba_ram.sv
hw/rtl/bba_seq.sv
hw/rtl/buddy_bitmap_allocator_top.sv
tb/buddy_bitmap_allocator_checker.sv
tb/buddy_bitmap_allocator_top_tb.sv
